// ===== design/hil_pkg.sv =====
// Package for the linear-probing hash insert engine.
// Sizes, payload structs, queue and table entry types, and the state enum.
// Depends on nothing; every other design file but hil_ram imports it.
`timescale 1ns / 1ps
`default_nettype none
package hil_pkg;

  // Table geometry
  localparam int MAX_LOG2_SLOTS = 12;
  localparam int MIN_LOG2_SLOTS = 8;
  localparam int DEPTH          = 1 << MAX_LOG2_SLOTS;
  localparam int SLOT_W         = MAX_LOG2_SLOTS;
  localparam int MAX_PROBES     = 256;
  localparam int PCNT_W         = $clog2(MAX_PROBES + 1);

  // Field widths
  localparam int KEY_BYTES = 8;
  localparam int HASH_W    = 64;
  localparam int KEY_W     = 64;
  localparam int LEN_W     = 4;
  localparam int VAL_W     = 32;
  localparam int SIZE_W    = 4;

  // Front queue depth
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Input transaction
  typedef struct packed {
    logic [HASH_W-1:0] hash;
    logic [KEY_W-1:0]  key_bytes;
    logic [LEN_W-1:0]  key_len;
    logic [VAL_W-1:0]  value_in;
  } hil_req_t;

  // Result transaction
  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic              inserted;
    logic              table_full;
    logic [VAL_W-1:0]  stored_value;
  } hil_rsp_t;

  // Classified item waiting for the probe engine
  typedef struct packed {
    logic [SLOT_W-1:0] start;
    logic [LEN_W-1:0]  len;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } hil_qent_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic      valid;
    hil_qent_t ent;
  } hil_q_t;

  // One table slot
  typedef struct packed {
    logic             valid;
    logic [LEN_W-1:0] len;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } hil_entry_t;

  localparam int ENTRY_W = $bits(hil_entry_t);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK
  } hil_state_e;

endpackage
`default_nettype wire

// ===== design/hil_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; width and depth come from parameters.
`timescale 1ns / 1ps
`default_nettype none
module hil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== design/hil_front.sv =====
// Front end: accepts transactions, clamps the key length, masks unused key
// bytes and queues the item for the probe engine. Uses hil_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hil_front import hil_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire hil_req_t req_i,
  input  wire logic     clearing_i,
  output hil_q_t        q_o,
  input  wire logic     pop_i
);

  hil_qent_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0]    wptr_q, wptr_d;
  logic [QPTR_W-1:0]    rptr_q, rptr_d;
  logic [QCNT_W-1:0]    cnt_q, cnt_d;
  logic                 push;
  logic                 full;
  logic [LEN_W-1:0]     len;
  logic [KEY_W-1:0]     key;
  hil_qent_t            ent;

  assign full = (cnt_q == QCNT_W'(QDEPTH));
  assign busy = full | clearing_i;
  assign push = start & ~busy;

  // Clamp length and drop key bytes beyond it
  always_comb begin
    len = req_i.key_len;
    if (len > LEN_W'(KEY_BYTES)) begin
      len = LEN_W'(KEY_BYTES);
    end
    key = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (LEN_W'(b) < len) begin
        key[b*8 +: 8] = req_i.key_bytes[b*8 +: 8];
      end
    end
    ent.start = req_i.hash[SLOT_W-1:0];
    ent.len   = len;
    ent.key   = key;
    ent.value = req_i.value_in;
  end

  // Advance queue pointers
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = rptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold queued items
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= ent;
    end
  end

  assign q_o.valid = (cnt_q != '0);
  assign q_o.ent   = mem_q[rptr_q];

endmodule
`default_nettype wire

// ===== design/hil_back.sv =====
// Back end: probe engine over the slot RAM, clearing sweep, size register
// and the result register. Uses hil_pkg and hil_ram.
`timescale 1ns / 1ps
`default_nettype none
module hil_back import hil_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [SIZE_W-1:0] cfg_wdata_i,
  input  wire hil_q_t            q_i,
  output logic                   pop_o,
  output logic                   clearing_o,
  output logic                   done_o,
  output hil_rsp_t               rsp_o
);

  hil_state_e        state_q, state_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [SLOT_W-1:0] clr_q, clr_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [PCNT_W-1:0] cnt_q, cnt_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [VAL_W-1:0]  val_q, val_d;
  logic              done_q, done_d;
  hil_rsp_t          rsp_q, rsp_d;

  logic [SIZE_W-1:0] size_use;
  logic [SLOT_W-1:0] mask;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  hil_entry_t        ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  hil_entry_t        ent;
  logic              empty;
  logic              match;
  logic              last;

  // Clamp size and build slot mask
  always_comb begin
    size_use = size_q;
    if (size_q < SIZE_W'(MIN_LOG2_SLOTS)) begin
      size_use = SIZE_W'(MIN_LOG2_SLOTS);
    end else if (size_q > SIZE_W'(MAX_LOG2_SLOTS)) begin
      size_use = SIZE_W'(MAX_LOG2_SLOTS);
    end
    for (int b = 0; b < SLOT_W; b++) begin
      mask[b] = (SIZE_W'(b) < size_use);
    end
  end

  // Classify the slot just read
  assign ent   = hil_entry_t'(ram_rdata);
  assign empty = ~ent.valid;
  assign match = ent.valid & (ent.len == len_q) & (ent.key == key_q);
  assign last  = (cnt_q == PCNT_W'(MAX_PROBES - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_i.valid) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (empty || match || last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
    if (cfg_we_i) begin
      state_d = ST_CLEAR;
    end
  end

  // Datapath and outputs
  always_comb begin
    size_d    = size_q;
    clr_d     = clr_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    key_d     = key_q;
    len_d     = len_q;
    val_d     = val_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata.valid = 1'b1;
    ram_wdata.len   = len_q;
    ram_wdata.key   = key_q;
    ram_wdata.value = val_q;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (q_i.valid) begin
          pop_o = 1'b1;
          idx_d = q_i.ent.start & mask;
          key_d = q_i.ent.key;
          len_d = q_i.ent.len;
          val_d = q_i.ent.value;
          cnt_d = '0;
        end
      end
      ST_CHECK: begin
        if (empty) begin
          ram_we             = 1'b1;
          done_d             = 1'b1;
          rsp_d.slot_index   = idx_q;
          rsp_d.inserted     = 1'b1;
          rsp_d.table_full   = 1'b0;
          rsp_d.stored_value = val_q;
        end else if (match) begin
          done_d             = 1'b1;
          rsp_d.slot_index   = idx_q;
          rsp_d.inserted     = 1'b0;
          rsp_d.table_full   = 1'b0;
          rsp_d.stored_value = ent.value;
        end else if (last) begin
          done_d             = 1'b1;
          rsp_d.slot_index   = '0;
          rsp_d.inserted     = 1'b0;
          rsp_d.table_full   = 1'b1;
          rsp_d.stored_value = '0;
        end else begin
          idx_d = (idx_q + 1'b1) & mask;
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
    // Restart the sweep on a size write
    if (cfg_we_i) begin
      size_d = cfg_wdata_i;
      clr_d  = '0;
      done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      size_q  <= SIZE_W'(MIN_LOG2_SLOTS);
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      size_q  <= size_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cnt_q <= cnt_d;
    key_q <= key_d;
    len_q <= len_d;
    val_q <= val_d;
    rsp_q <= rsp_d;
  end

  // Slot storage; the read address is idx_d, so the slot checked was addressed in the cycle before
  hil_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_d),
    .rdata_o (ram_rdata)
  );

  assign clearing_o = (state_q == ST_CLEAR);
  assign done_o     = done_q;
  assign rsp_o      = rsp_q;

endmodule
`default_nettype wire

// ===== design/hash_insert_linear_probe.sv =====
// Top level of the linear-probing hash insert engine.
// Joins hil_front and hil_back; uses hil_pkg.
//
//   channel   ports                        handshake
//   -------   --------------------------   -------------------------------
//   request   start, busy, req_i           taken when start & !busy
//   result    done_o, rsp_o                one-cycle strobe, never stalled
//   config    cfg_we_i, cfg_wdata_i        written when cfg_we_i is high
//
// An item is queued, then popped by the engine in ST_IDLE; the engine then probes
// slots one by one (1 to MAX_PROBES probes), reading each through the single read port
// of the slot RAM; the result strobe is registered from the deciding probe.
// After reset and after every size write, a clearing sweep over all DEPTH (4096)
// slots runs, with busy high. A two-entry queue lets requests in while a
// probe runs; busy rises only when the queue is full or during the sweep.
`timescale 1ns / 1ps
`default_nettype none
module hash_insert_linear_probe import hil_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire hil_req_t          req_i,
  output logic                   done_o,
  output hil_rsp_t               rsp_o,
  input  wire logic              cfg_we_i,
  input  wire logic [SIZE_W-1:0] cfg_wdata_i
);

  hil_q_t q;
  logic   pop;
  logic   clearing;

  // Accept and queue items
  hil_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .clearing_i (clearing),
    .q_o        (q),
    .pop_i      (pop)
  );

  // Probe the table
  hil_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_i         (q),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

endmodule
`default_nettype wire

// ===== design/hil_checker.sv =====
// Port-level checker for the hash insert engine, bound to the top level.
// Uses hil_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hil_checker import hil_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              busy,
  input wire logic              done_o,
  input wire hil_rsp_t          rsp_o,
  input wire logic              cfg_we_i
);

  // A full-table result carries nothing else
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.table_full |->
      !rsp_o.inserted && rsp_o.slot_index == '0 && rsp_o.stored_value == '0)
    else $error("table_full result with nonzero fields");

  // Insert and full never together
  a_ins_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.inserted |-> !rsp_o.table_full)
    else $error("inserted and table_full both set");

  // Size write starts the clearing sweep
  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy)
    else $error("busy low after size write");

  // No result right after a size write
  a_cfg_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !done_o)
    else $error("result after size write");

  // Busy stays up through the first sweep cycles
  a_cfg_busy2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> ##1 busy)
    else $error("sweep ended too early");

endmodule

bind hash_insert_linear_probe hil_checker u_hil_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .busy     (busy),
  .done_o   (done_o),
  .rsp_o    (rsp_o),
  .cfg_we_i (cfg_we_i)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for hash_insert_linear_probe: insert-or-find transactions
// are checked against an in-bench copy of the probed table, kept by a scoreboard class.
// Depends on hil_pkg and the design top level only.
`timescale 1ns / 1ps
module tb_top;
  import hil_pkg::*;

  // Scoreboard: mirrors the slot table and holds the expected slot results
  class slot_table_tracker;
    bit                slot_used [DEPTH];
    logic [KEY_W-1:0]  slot_key  [DEPTH];
    logic [LEN_W-1:0]  slot_len  [DEPTH];
    logic [VAL_W-1:0]  slot_val  [DEPTH];
    logic [SIZE_W-1:0] size_reg;
    hil_rsp_t          expected_slots[$];
    int unsigned       mismatches;

    function new();
      size_reg   = SIZE_W'(MIN_LOG2_SLOTS);
      mismatches = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    // Mask of the bytes that belong to a key of the given (clamped) length
    static function logic [KEY_W-1:0] byte_mask(logic [LEN_W-1:0] len);
      if (int'(len) >= KEY_BYTES) return '1;
      return (64'd1 << (int'(len) * 8)) - 64'd1;
    endfunction

    // A size write keeps the raw value and drops every entry
    function void write_size(logic [SIZE_W-1:0] v);
      size_reg = v;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    function int pending();
      return expected_slots.size();
    endfunction

    // Walk the table for one accepted request and queue its result
    function void note_request(hil_req_t r);
      int unsigned       lg;
      logic [SLOT_W-1:0] mask;
      logic [SLOT_W-1:0] idx;
      logic [LEN_W-1:0]  len;
      logic [KEY_W-1:0]  key;
      hil_rsp_t          rsp;
      bit                hit;
      lg = size_reg;
      if (lg < MIN_LOG2_SLOTS) lg = MIN_LOG2_SLOTS;
      if (lg > MAX_LOG2_SLOTS) lg = MAX_LOG2_SLOTS;
      mask = SLOT_W'((1 << lg) - 1);
      idx  = r.hash[SLOT_W-1:0] & mask;
      len  = (int'(r.key_len) > KEY_BYTES) ? LEN_W'(KEY_BYTES) : r.key_len;
      key  = r.key_bytes & byte_mask(len);
      rsp  = '0;
      rsp.table_full = 1'b1;
      hit = 1'b0;
      for (int p = 0; p < MAX_PROBES && !hit; p++) begin
        if (!slot_used[idx]) begin
          slot_used[idx] = 1'b1;
          slot_key[idx]  = key;
          slot_len[idx]  = len;
          slot_val[idx]  = r.value_in;
          rsp.slot_index   = idx;
          rsp.inserted     = 1'b1;
          rsp.table_full   = 1'b0;
          rsp.stored_value = r.value_in;
          hit = 1'b1;
        end else if (slot_len[idx] == len && slot_key[idx] == key) begin
          rsp.slot_index   = idx;
          rsp.inserted     = 1'b0;
          rsp.table_full   = 1'b0;
          rsp.stored_value = slot_val[idx];
          hit = 1'b1;
        end else begin
          idx = (idx + 1'b1) & mask;
        end
      end
      expected_slots.push_back(rsp);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("tb_top: mismatch on %s at %0t: got %0h, expected %0h", what, $realtime, got,
               want);
      mismatches++;
    endtask

    // Compare one result transaction with the oldest expectation
    task check_result(hil_rsp_t got);
      hil_rsp_t want;
      if (expected_slots.size() == 0) begin
        report_mismatch("unexpected result", 64'(got), 64'd0);
      end else begin
        want = expected_slots.pop_front();
        if (got.slot_index !== want.slot_index)
          report_mismatch("slot_index", 64'(got.slot_index), 64'(want.slot_index));
        if (got.inserted !== want.inserted)
          report_mismatch("inserted", 64'(got.inserted), 64'(want.inserted));
        if (got.table_full !== want.table_full)
          report_mismatch("table_full", 64'(got.table_full), 64'(want.table_full));
        if (got.stored_value !== want.stored_value)
          report_mismatch("stored_value", 64'(got.stored_value), 64'(want.stored_value));
      end
    endtask
  endclass

  // Keys already sent in this phase, reused to hit the found path
  typedef struct {
    logic [HASH_W-1:0] hash;
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  len;
  } known_key_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  hil_req_t          req = '0;
  logic              done_o;
  hil_rsp_t          rsp_o;
  logic              cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata = '0;

  slot_table_tracker tracker = new();
  known_key_t        known_keys[$];
  logic [SLOT_W-1:0] cluster_base;

  hash_insert_linear_probe dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #2 clk_i = ~clk_i;

  // Check every result strobe
  always @(posedge clk_i) begin
    if (rst_ni && done_o) tracker.check_result(rsp_o);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic hil_req_t noise_request();
    hil_req_t r;
    r.hash      = rand64();
    r.key_bytes = rand64();
    r.key_len   = LEN_W'($urandom_range(0, 15));
    r.value_in  = $urandom;
    return r;
  endfunction

  // Drive one transaction, idling first at the given rate
  task automatic send_request(hil_req_t r, int unsigned idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      start = 1'b0;
      req   = noise_request();
    end
    @(negedge clk_i);
    start = 1'b1;
    req   = r;
    do @(posedge clk_i); while (busy);
    tracker.note_request(r);
  endtask

  // Drop start and wait for every pending result, then let the engine settle
  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_table_size(logic [SIZE_W-1:0] v);
    drain();
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk_i);
    cfg_we    = 1'b0;
    cfg_wdata = SIZE_W'($urandom);
    tracker.write_size(v);
    known_keys.delete();
    cluster_base = SLOT_W'($urandom);
  endtask

  // Fresh key, sometimes landing in a cluster so probe chains grow and wrap
  function automatic hil_req_t fresh_request();
    hil_req_t   r;
    known_key_t k;
    r = noise_request();
    if ($urandom_range(0, 3) == 0) r.key_len = LEN_W'($urandom_range(0, 2));
    if ($urandom_range(0, 1) == 0)
      r.hash[SLOT_W-1:0] = cluster_base + SLOT_W'($urandom_range(0, 15));
    k.hash = r.hash;
    k.len  = (int'(r.key_len) > KEY_BYTES) ? LEN_W'(KEY_BYTES) : r.key_len;
    k.key  = r.key_bytes & slot_table_tracker::byte_mask(k.len);
    known_keys.push_back(k);
    return r;
  endfunction

  // Repeat a known key with new junk in the unused bytes and upper hash bits
  function automatic hil_req_t repeat_request();
    hil_req_t   r;
    known_key_t k;
    k = known_keys[$urandom_range(0, known_keys.size() - 1)];
    r.hash      = (rand64() & ~64'(DEPTH - 1)) | 64'(k.hash[SLOT_W-1:0]);
    r.key_bytes = k.key | (rand64() & ~slot_table_tracker::byte_mask(k.len));
    r.key_len   = (int'(k.len) == KEY_BYTES) ? LEN_W'($urandom_range(KEY_BYTES, 15)) : k.len;
    r.value_in  = $urandom;
    return r;
  endfunction

  // Mostly finds and inserts with random content, some pure noise
  task automatic run_mix(int n, int unsigned idle_pct);
    int unsigned pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (known_keys.size() != 0 && pick < 50) send_request(repeat_request(), idle_pct);
      else if (pick < 90) send_request(fresh_request(), idle_pct);
      else send_request(noise_request(), idle_pct);
    end
  endtask

  // Distinct full-length keys until the table overflows
  task automatic run_fill(int n, int unsigned idle_pct);
    hil_req_t   r;
    known_key_t k;
    for (int i = 0; i < n; i++) begin
      r.hash      = rand64();
      r.key_bytes = {$urandom, 32'(i)};
      r.key_len   = LEN_W'(KEY_BYTES);
      r.value_in  = $urandom;
      k.hash = r.hash;
      k.key  = r.key_bytes;
      k.len  = r.key_len;
      known_keys.push_back(k);
      send_request(r, idle_pct);
    end
  endtask

  task automatic send_fields(logic [63:0] h, logic [63:0] kb, logic [3:0] kl, logic [31:0] v);
    hil_req_t r;
    r.hash      = h;
    r.key_bytes = kb;
    r.key_len   = kl;
    r.value_in  = v;
    send_request(r, 0);
  endtask

  // Timeout
  initial begin
    #10_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    cluster_base = SLOT_W'($urandom);
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset size, extremes, zero-length keys, long lengths, wrap
    send_fields(64'd0, 64'd0, 4'd0, 32'd0);
    send_fields('1, '1, 4'd8, '1);
    send_fields(64'h0000_0000_0000_00ff, 64'h1, 4'd1, 32'h0000_0001);
    send_fields(64'd0, '1, 4'd0, 32'h5);
    send_fields('1, '1, 4'd15, 32'h1234_5678);
    send_fields(64'h0000_0000_0000_00ff, 64'hab01, 4'd1, 32'h9);
    send_fields(64'h0000_0000_0000_00ff, 64'h0001, 4'd2, 32'h8000_0000);
    send_fields(64'h8000_0000_0000_0080, 64'hdead_beef, 4'd4, 32'h7fff_ffff);
    for (int l = 0; l < 16; l++) send_fields(rand64(), rand64(), 4'(l), $urandom);

    // Random phases over several table sizes and sender idle rates
    write_table_size(4'd12);
    run_mix(250, 0);
    write_table_size(4'd0);
    run_mix(200, 67);
    write_table_size(4'd15);
    run_mix(200, 19);
    write_table_size(4'd8);
    run_fill(300, 0);
    run_mix(40, 19);
    write_table_size(4'd10);
    run_mix(120, 67);

    drain();
    repeat (16) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/hil_pkg.sv
design/hil_ram.sv
design/hil_front.sv
design/hil_back.sv
design/hash_insert_linear_probe.sv
design/hil_checker.sv
tb/tb_top.sv
